>>> hdl/smpu_pkg.sv
package smpu_pkg;

	localparam int CORDIC_STEPS = 30;
	localparam int PRE_SHIFT = 16;
	localparam int Z_W = 34;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 17;

	localparam longint Q30_PI = 64'sd3373259426;
	localparam longint Q30_HALF_PI = 64'sd1686629713;

	localparam logic [CFG_IDX_W-1:0] REG_PHASE_MODE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_UNWRAP_ENABLE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_SHIFT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_LENGTH = 3'd3;

	typedef logic signed [Z_W-1:0] angle_t;

	localparam angle_t Z_HALF_PI = angle_t'(Q30_HALF_PI);

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

	// arctan(2^-i) in Q30
	function automatic angle_t atan_q30(input logic [4:0] idx);
		angle_t r;
		case (idx)
			5'd0: r = 34'sd843314857;
			5'd1: r = 34'sd497837829;
			5'd2: r = 34'sd263043837;
			5'd3: r = 34'sd133525159;
			5'd4: r = 34'sd67021687;
			5'd5: r = 34'sd33543516;
			5'd6: r = 34'sd16775851;
			5'd7: r = 34'sd8388437;
			5'd8: r = 34'sd4194283;
			5'd9: r = 34'sd2097149;
			5'd10: r = 34'sd1048576;
			5'd11: r = 34'sd524288;
			5'd12: r = 34'sd262144;
			5'd13: r = 34'sd131072;
			5'd14: r = 34'sd65536;
			5'd15: r = 34'sd32768;
			5'd16: r = 34'sd16384;
			5'd17: r = 34'sd8192;
			5'd18: r = 34'sd4096;
			5'd19: r = 34'sd2048;
			5'd20: r = 34'sd1024;
			5'd21: r = 34'sd512;
			5'd22: r = 34'sd256;
			5'd23: r = 34'sd128;
			5'd24: r = 34'sd64;
			5'd25: r = 34'sd32;
			5'd26: r = 34'sd16;
			5'd27: r = 34'sd8;
			5'd28: r = 34'sd4;
			5'd29: r = 34'sd2;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

>>> hdl/smpu_cordic.sv
module smpu_cordic import smpu_pkg::*; #(
	parameter int SAMPLE_BITS = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [SAMPLE_BITS-1:0] re,
	input  logic [SAMPLE_BITS-1:0] im,
	output unit_stat_t             stat,
	output angle_t                 angle
);

	localparam int XW = SAMPLE_BITS + PRE_SHIFT + 2;

	typedef enum logic [1:0] {C_IDLE, C_ITER, C_DONE} cstate_t;

	cstate_t state_q;
	logic [4:0] step_q;
	logic signed [XW-1:0] x_q, y_q, xe, ye, dx, dy;
	angle_t z_q;

	always_comb begin
		xe = {{2{re[SAMPLE_BITS-1]}}, re, {PRE_SHIFT{1'b0}}};
		ye = {{2{im[SAMPLE_BITS-1]}}, im, {PRE_SHIFT{1'b0}}};
		dx = y_q >>> step_q;
		dy = x_q >>> step_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			step_q <= '0;
		end else begin
			case (state_q)
				C_IDLE, C_DONE: begin
					if (start) begin
						state_q <= C_ITER;
						step_q <= '0;
					end
				end
				C_ITER: begin
					step_q <= step_q + 5'd1;
					if (step_q == 5'(CORDIC_STEPS - 1))
						state_q <= C_DONE;
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start && state_q != C_ITER) begin
			if (xe < 0) begin
				if (ye >= 0) begin
					x_q <= ye;
					y_q <= -xe;
					z_q <= Z_HALF_PI;
				end else begin
					x_q <= -ye;
					y_q <= xe;
					z_q <= -Z_HALF_PI;
				end
			end else begin
				x_q <= xe;
				y_q <= ye;
				z_q <= '0;
			end
		end else if (state_q == C_ITER) begin
			if (y_q > 0) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + atan_q30(step_q);
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - atan_q30(step_q);
			end
		end
	end

	assign stat.busy = (state_q == C_ITER);
	assign stat.done = (state_q == C_DONE);
	assign angle = z_q;

endmodule

>>> hdl/smpu_isqrt.sv
module smpu_isqrt import smpu_pkg::*; #(
	parameter int SAMPLE_BITS = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [SAMPLE_BITS-1:0] re,
	input  logic [SAMPLE_BITS-1:0] im,
	output unit_stat_t             stat,
	output logic [SAMPLE_BITS-1:0] root
);

	localparam int SQ_W = 2 * SAMPLE_BITS;
	localparam int RW = SAMPLE_BITS + 3;
	localparam int SCW = $clog2(SAMPLE_BITS);

	typedef enum logic [2:0] {M_IDLE, M_SQ_RE, M_SQ_IM, M_SUM, M_ROOT, M_DONE} mstate_t;

	mstate_t state_q;
	logic [SCW-1:0] cnt_q;
	logic signed [SAMPLE_BITS-1:0] re_q, im_q, mul_op;
	logic signed [SQ_W-1:0] sq;
	logic [SQ_W-1:0] prod_q, sum_q, n_q;
	logic [RW-1:0] rem_q, rem_sh, trial;
	logic [SAMPLE_BITS-1:0] root_q;

	always_comb begin
		mul_op = (state_q == M_SQ_RE) ? re_q : im_q;
		sq = mul_op * mul_op;
		rem_sh = {rem_q[RW-3:0], n_q[SQ_W-1 -: 2]};
		trial = {1'b0, root_q, 2'b01};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			cnt_q <= '0;
		end else begin
			case (state_q)
				M_IDLE, M_DONE: begin
					if (start)
						state_q <= M_SQ_RE;
				end
				M_SQ_RE: state_q <= M_SQ_IM;
				M_SQ_IM: state_q <= M_SUM;
				M_SUM: begin
					state_q <= M_ROOT;
					cnt_q <= '0;
				end
				M_ROOT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == SCW'(SAMPLE_BITS - 1))
						state_q <= M_DONE;
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start && (state_q == M_IDLE || state_q == M_DONE)) begin
			re_q <= re;
			im_q <= im;
		end
		case (state_q)
			M_SQ_RE: prod_q <= SQ_W'(sq);
			M_SQ_IM: begin
				sum_q <= prod_q;
				prod_q <= SQ_W'(sq);
			end
			M_SUM: begin
				n_q <= sum_q + prod_q;
				rem_q <= '0;
				root_q <= '0;
			end
			M_ROOT: begin
				n_q <= n_q << 2;
				if (rem_sh >= trial) begin
					rem_q <= rem_sh - trial;
					root_q <= {root_q[SAMPLE_BITS-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					root_q <= {root_q[SAMPLE_BITS-2:0], 1'b0};
				end
			end
			default: ;
		endcase
	end

	assign stat.busy = (state_q != M_IDLE) && (state_q != M_DONE);
	assign stat.done = (state_q == M_DONE);
	assign root = root_q;

endmodule

>>> hdl/spectrum_magnitude_phase_unwrap_top.sv
// Turns one complex spectrum bin into one plot point. An accepted bin is worked
// on by an iterative 30-step CORDIC for the angle and, alongside it, a squaring
// multiplier followed by a one-bit-per-cycle square root for the magnitude;
// once both units finish, the ROUND, WRAP and EMIT states round the angle, wrap
// the phase jump and update the saturating unwrap accumulator, and the block
// returns to IDLE. The block takes no new bin until it is back in IDLE, which
// waits on the CORDIC iteration count or the square-root digit loop, whichever
// ends later, and on the output register freeing up; in_ready is low meanwhile.
// A result waits in the output register while the next bin runs.
// Configuration writes belong between frames or while the block is idle.
module spectrum_magnitude_phase_unwrap_top import smpu_pkg::*; #(
	parameter int MAX_FRAME = 65536,
	parameter int SAMPLE_BITS = 24,
	parameter int PHASE_FRAC_BITS = 13
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [SAMPLE_BITS-1:0] real_part,
	input  logic [SAMPLE_BITS-1:0] imag_part,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [17:0]            x_coord,
	output logic [31:0]            y_value,
	output logic                   frame_end
);

	localparam int RS = 30 - PHASE_FRAC_BITS;
	localparam int PW = PHASE_FRAC_BITS + 3;
	localparam int DW = PW + 2;
	localparam int CW = $clog2(MAX_FRAME);
	localparam longint PQ_L = (Q30_PI + (longint'(1) <<< (RS - 1))) >>> RS;
	localparam angle_t PQ_Z = angle_t'(PQ_L);
	localparam logic signed [DW-1:0] PQ_D = DW'(PQ_L);
	localparam logic signed [DW-1:0] TWO_PQ_D = DW'(2 * PQ_L);

	typedef enum logic [2:0] {S_IDLE, S_RUN, S_ROUND, S_WRAP, S_EMIT} state_t;

	state_t state_q;
	logic phase_mode_q, unwrap_q, shift_q;
	logic [CFG_DATA_W-1:0] frame_len_q, len_c;
	logic [CW-1:0] bin_cnt_q;
	logic signed [PW-1:0] prior_q, ph_q, ph_next;
	logic signed [31:0] acc_q, acc_sat;
	logic signed [DW-1:0] d_q, d_raw, d_wrap;
	logic signed [32:0] acc_sum;
	logic zero_q, start, last, load;
	logic [17:0] xc;
	logic [31:0] y_sel, mag_sat;
	angle_t angle, zr, zs, zc;
	logic [SAMPLE_BITS-1:0] root;
	unit_stat_t cstat, mstat;
	logic out_valid_q, frame_end_q;
	logic [17:0] x_coord_q;
	logic [31:0] y_value_q;

	assign in_ready = (state_q == S_IDLE);
	assign start = in_valid && in_ready;
	assign load = (state_q == S_EMIT) && (!out_valid_q || out_ready);

	smpu_cordic #(.SAMPLE_BITS(SAMPLE_BITS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .start(start),
		.re(real_part), .im(imag_part), .stat(cstat), .angle(angle)
	);

	smpu_isqrt #(.SAMPLE_BITS(SAMPLE_BITS)) u_isqrt (
		.clk(clk), .arst_n(arst_n), .start(start),
		.re(real_part), .im(imag_part), .stat(mstat), .root(root)
	);

	always_comb begin
		if (frame_len_q < CFG_DATA_W'(2))
			len_c = CFG_DATA_W'(2);
		else if (frame_len_q > CFG_DATA_W'(MAX_FRAME))
			len_c = CFG_DATA_W'(MAX_FRAME);
		else
			len_c = frame_len_q;
		last = CFG_DATA_W'(bin_cnt_q) >= (len_c - CFG_DATA_W'(1));
		xc = 18'(bin_cnt_q) + 18'd1 - (shift_q ? 18'(len_c >> 1) : 18'd0);

		// round half up, clamp to +-pi
		zr = angle + (angle_t'(1) <<< (RS - 1));
		zs = zr >>> RS;
		if (zs > PQ_Z)
			zc = PQ_Z;
		else if (zs < -PQ_Z)
			zc = -PQ_Z;
		else
			zc = zs;
		ph_next = zero_q ? '0 : PW'(zc);

		d_raw = DW'(ph_q) - DW'(prior_q);
		if (d_raw > PQ_D)
			d_wrap = d_raw - TWO_PQ_D;
		else if (d_raw < -PQ_D)
			d_wrap = d_raw + TWO_PQ_D;
		else
			d_wrap = d_raw;

		if (bin_cnt_q == '0)
			acc_sum = 33'(ph_q);
		else
			acc_sum = 33'(acc_q) + 33'(d_q);
		if (acc_sum > 33'sh0_7FFF_FFFF)
			acc_sat = 32'sh7FFF_FFFF;
		else if (acc_sum < -33'sh0_8000_0000)
			acc_sat = 32'sh8000_0000;
		else
			acc_sat = 32'(acc_sum);

		if (33'(root) > 33'h0_7FFF_FFFF)
			mag_sat = 32'h7FFF_FFFF;
		else
			mag_sat = 32'(root);

		if (phase_mode_q)
			y_sel = unwrap_q ? acc_sat : 32'(ph_q);
		else
			y_sel = mag_sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_mode_q <= 1'b0;
			unwrap_q <= 1'b0;
			shift_q <= 1'b0;
			frame_len_q <= CFG_DATA_W'(1024);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PHASE_MODE: phase_mode_q <= cfg_data[0];
				REG_UNWRAP_ENABLE: unwrap_q <= cfg_data[0];
				REG_CENTER_SHIFT: shift_q <= cfg_data[0];
				REG_FRAME_LENGTH: frame_len_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			bin_cnt_q <= '0;
			prior_q <= '0;
			acc_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start)
						state_q <= S_RUN;
				end
				S_RUN: begin
					if (cstat.done && mstat.done)
						state_q <= S_ROUND;
				end
				S_ROUND: state_q <= S_WRAP;
				S_WRAP: state_q <= S_EMIT;
				S_EMIT: begin
					if (load) begin
						state_q <= S_IDLE;
						prior_q <= ph_q;
						acc_q <= acc_sat;
						bin_cnt_q <= last ? '0 : bin_cnt_q + 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start)
			zero_q <= (real_part == '0) && (imag_part == '0);
		if (state_q == S_ROUND)
			ph_q <= ph_next;
		if (state_q == S_WRAP)
			d_q <= d_wrap;
		if (load) begin
			x_coord_q <= xc;
			y_value_q <= y_sel;
			frame_end_q <= last;
		end
	end

	assign out_valid = out_valid_q;
	assign x_coord = x_coord_q;
	assign y_value = y_value_q;
	assign frame_end = frame_end_q;

`ifndef SYNTHESIS
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a bin is in work");

	a_units_block_input: assert property (@(posedge clk) disable iff (!arst_n)
		(cstat.busy || mstat.busy) |-> !in_ready)
		else $error("ready while an arithmetic unit is busy");

	a_frame_end_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |-> bin_cnt_q == '0)
		else $error("bin counter not restarted after last bin");
`endif

endmodule
